// ===== rtl/gcd_pkg.sv =====
// shared constants and controller/datapath interface types for the gcd unit
package gcd_pkg;

	localparam int OPERAND_WIDTH = 32;
	localparam int DIVISOR_WIDTH = OPERAND_WIDTH - 1;
	localparam int SHIFT_WIDTH   = $clog2(DIVISOR_WIDTH);

	typedef struct packed {
		logic load;
		logic step;
		logic capture;
	} gcd_cmd_t;

	typedef struct packed {
		logic equal;
	} gcd_status_t;

endpackage

// ===== rtl/gcd_ctrl.sv =====
// controller state machine and output beat tracking for the gcd unit
module gcd_ctrl
	import gcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  gcd_status_t status,
	output gcd_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_next  = state_q;
		cmd.load    = 1'b0;
		cmd.step    = 1'b0;
		cmd.capture = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = S_RUN;
				end
			end
			S_RUN: begin
				if (status.equal) begin
					state_next = S_DONE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.capture = 1'b1;
					state_next  = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/gcd_dp.sv =====
// binary gcd datapath: operand registers, shift count and result register
module gcd_dp
	import gcd_pkg::*;
(
	input  logic                            clk,
	input  logic signed [OPERAND_WIDTH-1:0] first_operand,
	input  logic signed [OPERAND_WIDTH-1:0] second_operand,
	input  gcd_cmd_t                        cmd,
	output gcd_status_t                     status,
	output logic        [DIVISOR_WIDTH-1:0] divisor
);

	logic [DIVISOR_WIDTH-1:0] x_q;
	logic [DIVISOR_WIDTH-1:0] y_q;
	logic [SHIFT_WIDTH-1:0]   shift_q;
	logic [DIVISOR_WIDTH-1:0] divisor_q;
	logic [DIVISOR_WIDTH:0]   x_minus_y;
	logic [DIVISOR_WIDTH-1:0] y_minus_x;
	logic                     x_greater;
	logic                     both_positive;

	// positive means nonzero with a clear sign bit
	assign both_positive = (first_operand > 0) && (second_operand > 0);

	assign x_minus_y    = {1'b0, x_q} - {1'b0, y_q};
	assign y_minus_x    = y_q - x_q;
	assign x_greater    = !x_minus_y[DIVISOR_WIDTH] && (x_q != y_q);
	assign status.equal = (x_q == y_q);
	assign divisor      = divisor_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			shift_q <= '0;
			if (both_positive) begin
				x_q <= first_operand[DIVISOR_WIDTH-1:0];
				y_q <= second_operand[DIVISOR_WIDTH-1:0];
			end else begin
				x_q <= DIVISOR_WIDTH'(1);
				y_q <= DIVISOR_WIDTH'(1);
			end
		end else if (cmd.step) begin
			case ({x_q[0], y_q[0]})
				2'b00: begin
					x_q     <= x_q >> 1;
					y_q     <= y_q >> 1;
					shift_q <= shift_q + SHIFT_WIDTH'(1);
				end
				2'b01: begin
					x_q <= x_q >> 1;
				end
				2'b10: begin
					y_q <= y_q >> 1;
				end
				default: begin
					// both odd: the larger takes the difference
					if (x_greater) begin
						x_q <= x_minus_y[DIVISOR_WIDTH-1:0];
					end else begin
						y_q <= y_minus_x;
					end
				end
			endcase
		end
		if (cmd.capture) begin
			divisor_q <= x_q << shift_q;
		end
	end

endmodule

// ===== rtl/greatest_common_divisor_unit.sv =====
// greatest common divisor unit: top level joining controller and datapath
//
// input channel: in_valid/in_ready with first_operand and second_operand,
// two signed 32-bit values. output channel: out_valid/out_ready with
// divisor, 31 bits unsigned. one result beat for every input beat.
// the result is the gcd when both operands are positive, else 1.
// an input beat is taken only while the controller is idle; it is loaded,
// then the binary gcd loop does one shift or one subtract per cycle until
// both working values match, then the output register is written. the
// loop's step count, which grows with the operand width, sets the time
// that an item takes; a new item is taken only after the last is written.
// the output register holds a finished result while the next item is
// already accepted and worked on; a stalled receiver holds the block only
// once a second result is ready to be written.
// asynchronous reset clears the controller and the output valid; nothing
// is kept between items.
module greatest_common_divisor_unit
	import gcd_pkg::*;
(
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [OPERAND_WIDTH-1:0] first_operand,
	input  logic signed [OPERAND_WIDTH-1:0] second_operand,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic        [DIVISOR_WIDTH-1:0] divisor
);

	gcd_cmd_t    cmd;
	gcd_status_t status;

	gcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	gcd_dp u_dp (
		.clk           (clk),
		.first_operand (first_operand),
		.second_operand(second_operand),
		.cmd           (cmd),
		.status        (status),
		.divisor       (divisor)
	);

	// one command at a time
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.step, cmd.capture}))
		else $error("more than one datapath command at once");

	// a result is written only once the loop has converged
	a_capture_converged: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> status.equal)
		else $error("result captured before convergence");

	// no new beat right after one was taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while busy");

	// a result is never zero
	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (divisor != '0))
		else $error("zero divisor delivered");

endmodule
